### hdl/efd_pkg.sv
`timescale 1ns / 1ps

package efd_pkg;

  localparam int MAX_FRAME_LEN = 32;
  localparam int LEN_W = 8;

  localparam logic [7:0] CODE_START = 8'h30;
  localparam logic [7:0] CODE_END   = 8'h20;
  localparam logic [7:0] CODE_ESC   = 8'hF0;
  localparam logic [7:0] REP_START  = 8'hF1;
  localparam logic [7:0] REP_END    = 8'hF2;
  localparam logic [7:0] REP_ESC    = 8'hF3;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_BOOT = 1'b1;

  typedef logic [LEN_W-1:0] len_t;

  typedef struct packed {
    logic kind;
    len_t len;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT
  } back_state_e;

  function automatic logic [7:0] unescape(input logic [7:0] b);
    logic [7:0] r;
    case (b)
      REP_START: r = CODE_START;
      REP_END:   r = CODE_END;
      REP_ESC:   r = CODE_ESC;
      default:   r = b;
    endcase
    return r;
  endfunction

endpackage

### hdl/efd_ram.sv
`timescale 1ns / 1ps

module efd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/efd_front.sv
`timescale 1ns / 1ps

module efd_front #(
  parameter int MAX_FRAME_LEN = efd_pkg::MAX_FRAME_LEN
) (
  input  logic                                                    clk_i,
  input  logic                                                    rst_ni,
  input  logic                                                    accept_i,
  input  logic [7:0]                                              rx_byte_i,
  input  logic [7:0]                                              command_count_i,
  output logic                                                    we_o,
  output logic [(MAX_FRAME_LEN > 1 ? $clog2(MAX_FRAME_LEN) : 1)-1:0] waddr_o,
  output logic [7:0]                                              wdata_o,
  output logic                                                    cmd_push_o,
  output efd_pkg::cmd_t                                           cmd_o
);

  localparam int CntW = $clog2(MAX_FRAME_LEN + 1);
  localparam int AddrW = MAX_FRAME_LEN > 1 ? $clog2(MAX_FRAME_LEN) : 1;

  logic [CntW-1:0] fill_q, fill_d;
  logic            esc_q, esc_d;
  logic [7:0]      first_q, first_d;
  logic [7:0]      decoded;

  assign decoded = esc_q ? efd_pkg::unescape(rx_byte_i) : rx_byte_i;

  always_comb begin
    fill_d     = fill_q;
    esc_d      = esc_q;
    first_d    = first_q;
    we_o       = 1'b0;
    waddr_o    = fill_q[AddrW-1:0];
    wdata_o    = decoded;
    cmd_push_o = 1'b0;
    cmd_o.kind = efd_pkg::KIND_DATA;
    cmd_o.len  = efd_pkg::len_t'(fill_q);
    if (accept_i) begin
      case (rx_byte_i)
        efd_pkg::CODE_START: begin
          fill_d = '0;
          esc_d  = 1'b0;
        end
        efd_pkg::CODE_END: begin
          if (fill_q == '0) begin
            cmd_push_o = 1'b1;
            cmd_o.kind = efd_pkg::KIND_BOOT;
          end else if (first_q < command_count_i) begin
            cmd_push_o = 1'b1;
          end
        end
        efd_pkg::CODE_ESC: begin
          esc_d = 1'b1;
        end
        default: begin
          if (fill_q < CntW'(MAX_FRAME_LEN)) begin
            we_o   = 1'b1;
            esc_d  = 1'b0;
            fill_d = fill_q + CntW'(1);
            if (fill_q == '0) begin
              first_d = decoded;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      esc_q  <= 1'b0;
    end else begin
      fill_q <= fill_d;
      esc_q  <= esc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
  end

endmodule

### hdl/efd_cmd_queue.sv
`timescale 1ns / 1ps

module efd_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  efd_pkg::cmd_t data_i,
  input  logic          pop_i,
  output logic          empty_o,
  output logic          full_o,
  output efd_pkg::cmd_t data_o
);

  efd_pkg::cmd_t entry_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    count_q;
  logic          do_push, do_pop;

  assign empty_o = count_q == 2'd0;
  assign full_o  = count_q == 2'd2;
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### hdl/efd_back.sv
`timescale 1ns / 1ps

module efd_back #(
  parameter int MAX_FRAME_LEN = efd_pkg::MAX_FRAME_LEN
) (
  input  logic                                                    clk_i,
  input  logic                                                    rst_ni,
  input  logic                                                    cmd_valid_i,
  input  efd_pkg::cmd_t                                           cmd_i,
  output logic                                                    cmd_pop_o,
  output logic                                                    busy_o,
  output logic                                                    re_o,
  output logic [(MAX_FRAME_LEN > 1 ? $clog2(MAX_FRAME_LEN) : 1)-1:0] raddr_o,
  input  logic [7:0]                                              rdata_i,
  input  logic                                                    pop,
  output logic                                                    empty,
  output logic                                                    result_kind_o,
  output logic [7:0]                                              data_byte_o,
  output logic [5:0]                                              frame_length_o,
  output logic                                                    last_byte_o
);

  localparam int CntW = $clog2(MAX_FRAME_LEN + 1);
  localparam int AddrW = MAX_FRAME_LEN > 1 ? $clog2(MAX_FRAME_LEN) : 1;

  efd_pkg::back_state_e state_q, state_d;
  logic [CntW-1:0]      idx_q, idx_d;
  efd_pkg::len_t        len_q, len_d;
  logic                 out_valid_q, out_valid_d;
  logic                 load;
  logic                 kind_d, last_d;
  logic [7:0]           byte_d;
  logic [5:0]           length_d;
  logic                 out_free, at_last;

  assign out_free = !out_valid_q || pop;
  assign at_last  = (efd_pkg::len_t'(idx_q) + efd_pkg::len_t'(1)) == len_q;
  assign busy_o   = state_q != efd_pkg::ST_IDLE;
  assign raddr_o  = idx_q[AddrW-1:0];

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    len_d       = len_q;
    cmd_pop_o   = 1'b0;
    re_o        = 1'b0;
    load        = 1'b0;
    kind_d      = efd_pkg::KIND_DATA;
    byte_d      = rdata_i;
    length_d    = 6'(len_q);
    last_d      = at_last;
    out_valid_d = out_valid_q && !pop;
    case (state_q)
      efd_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.kind == efd_pkg::KIND_BOOT) begin
            if (out_free) begin
              cmd_pop_o = 1'b1;
              load      = 1'b1;
              kind_d    = efd_pkg::KIND_BOOT;
              byte_d    = 8'h00;
              length_d  = 6'd0;
              last_d    = 1'b1;
            end
          end else begin
            cmd_pop_o = 1'b1;
            len_d     = cmd_i.len;
            idx_d     = '0;
            state_d   = efd_pkg::ST_READ;
          end
        end
      end
      efd_pkg::ST_READ: begin
        re_o    = 1'b1;
        state_d = efd_pkg::ST_WAIT;
      end
      efd_pkg::ST_WAIT: begin
        if (out_free) begin
          load = 1'b1;
          if (at_last) begin
            state_d = efd_pkg::ST_IDLE;
          end else begin
            idx_d   = idx_q + CntW'(1);
            state_d = efd_pkg::ST_READ;
          end
        end
      end
      default: begin
        state_d = efd_pkg::ST_IDLE;
      end
    endcase
    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= efd_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    len_q <= len_d;
    if (load) begin
      result_kind_o  <= kind_d;
      data_byte_o    <= byte_d;
      frame_length_o <= length_d;
      last_byte_o    <= last_d;
    end
  end

  assign empty = !out_valid_q;

endmodule

### hdl/escaped_frame_deframer_core.sv
`timescale 1ns / 1ps

// Deframer for a byte-stuffed serial stream. Each received byte updates the
// frame store; full is high while an end byte's work is queued or while the
// stored frame is being read out. An end byte that emits a frame of N bytes
// holds off input while the queued work passes to the read-out and, for every
// result byte, the read-out does one read of the registered frame store and
// then loads the output word. An end byte on an empty frame gives one
// bootloader-request word, and a frame whose command id is not below
// command_count gives no word at all. Results wait in a one-word output
// register, so reading out stalls only when that word is not popped.
module escaped_frame_deframer_core #(
  parameter int MAX_FRAME_LEN = efd_pkg::MAX_FRAME_LEN
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic       result_kind_o,
  output logic [7:0] data_byte_o,
  output logic [5:0] frame_length_o,
  output logic       last_byte_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  localparam int AddrW = MAX_FRAME_LEN > 1 ? $clog2(MAX_FRAME_LEN) : 1;

  logic [7:0]       command_count_q;
  logic             accept;
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;
  logic             q_push, q_pop, q_empty, q_full;
  efd_pkg::cmd_t    q_in, q_out;
  logic             back_busy;

  assign cfg_ready_o = 1'b1;
  assign full        = !q_empty || back_busy;
  assign accept      = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      command_count_q <= 8'h00;
    end else if (cfg_valid_i && cfg_ready_o) begin
      command_count_q <= cfg_data_i;
    end
  end

  efd_front #(
    .MAX_FRAME_LEN(MAX_FRAME_LEN)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .rx_byte_i      (rx_byte_i),
    .command_count_i(command_count_q),
    .we_o           (ram_we),
    .waddr_o        (ram_waddr),
    .wdata_o        (ram_wdata),
    .cmd_push_o     (q_push),
    .cmd_o          (q_in)
  );

  efd_ram #(
    .WIDTH(8),
    .DEPTH(MAX_FRAME_LEN)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  efd_cmd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_in),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .full_o (q_full),
    .data_o (q_out)
  );

  efd_back #(
    .MAX_FRAME_LEN(MAX_FRAME_LEN)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (!q_empty),
    .cmd_i         (q_out),
    .cmd_pop_o     (q_pop),
    .busy_o        (back_busy),
    .re_o          (ram_re),
    .raddr_o       (ram_raddr),
    .rdata_i       (ram_rdata),
    .pop           (pop),
    .empty         (empty),
    .result_kind_o (result_kind_o),
    .data_byte_o   (data_byte_o),
    .frame_length_o(frame_length_o),
    .last_byte_o   (last_byte_o)
  );

  // The store is never written while a frame is being read out of it.
  assert property (@(posedge clk_i) disable iff (!rst_ni) ram_we |-> !back_busy)
    else $error("frame store written during read-out");

  // Only one end byte's work is outstanding at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> (q_empty && !q_full))
    else $error("command queue pushed while not empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_empty)
    else $error("command queue popped while empty");

endmodule
